// ===== rtl/pmpa_pkg.sv =====
// Shared constants, types and helper functions of the power monitor core.
package pmpa_pkg;

  localparam int WindowSlots = 32;
  localparam int SlotW = (WindowSlots > 1) ? $clog2(WindowSlots) : 1;
  localparam int CntW = $clog2(WindowSlots + 1);

  localparam int BusW = 16;
  localparam int ShuntW = 16;
  localparam int VoltW = 17;
  localparam int CurrW = 14;
  localparam int DecW = 4;
  localparam int WinW = 6;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 6;

  localparam int VoltSumW = VoltW + SlotW;
  localparam int CurrSumW = CurrW + SlotW;
  localparam int DivW = VoltSumW;
  localparam int DivCntW = $clog2(DivW);

  localparam logic [DecW-1:0] DecReset = DecW'(4);
  localparam logic [WinW-1:0] WinReset = WinW'(25);

  typedef enum logic {
    OpSample = 1'b0,
    OpClear  = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDecimation = 1'b0,
    CfgWindow     = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StEval,
    StSum,
    StDiv,
    StFinish
  } state_e;

  typedef struct packed {
    logic accept;
    logic sum_init;
    logic sum_run;
    logic div_start;
    logic avg_load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic run_avg;
    logic sum_done;
    logic div_done;
  } status_t;

  function automatic logic [CurrW-1:0] abs_curr(input logic [CurrW-1:0] v);
    abs_curr = v[CurrW-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// ===== rtl/power_monitor_peak_average_core.sv =====
// Top level of the power monitor core: live, peak and moving-average readings.
//
// A transaction on the input channel carries an operation, a raw bus reading and a
// signed raw shunt reading. A sample is scaled, folded into the peaks and, every
// decimation_count samples, stored in a ring of window_length history slots. A clear
// restarts the peaks from the live values and empties the ring. Every input
// transaction yields exactly one output transaction with the live, peak and average
// values after that item.
// The configuration channel is always ready. It is to be written only while the core is
// idle; the core itself does not enforce this. A clear, or a sample while the ring is
// empty, passes from acceptance through the evaluate and finish states to the output
// register. A sample with filled slots (a full ring holds 32) sums them with one history
// read per cycle, then runs the bit-serial dividers. One item is processed at a time.
// The output register holds a finished result while the receiver stalls; the next
// item is accepted meanwhile and waits before its own result is loaded.
// Reset clears the readings, the ring pointers and the decimation count, and restores
// the configuration defaults. History slots hold no value until written.
module power_monitor_peak_average_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pmpa_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [pmpa_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                operation_i,
  input  logic [pmpa_pkg::BusW-1:0]           raw_bus_i,
  input  logic signed [pmpa_pkg::ShuntW-1:0]  raw_shunt_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [pmpa_pkg::VoltW-1:0]          live_volt_mv_o,
  output logic signed [pmpa_pkg::CurrW-1:0]   live_curr_ua_o,
  output logic [pmpa_pkg::VoltW-1:0]          peak_volt_mv_o,
  output logic [pmpa_pkg::CurrW-1:0]          peak_curr_ua_o,
  output logic [pmpa_pkg::VoltW-1:0]          avg_volt_mv_o,
  output logic signed [pmpa_pkg::CurrW-1:0]   avg_curr_ua_o
);

  pmpa_pkg::cmd_t    cmd;
  pmpa_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  pmpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  pmpa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .operation_i    (operation_i),
    .raw_bus_i      (raw_bus_i),
    .raw_shunt_i    (raw_shunt_i),
    .live_volt_mv_o (live_volt_mv_o),
    .live_curr_ua_o (live_curr_ua_o),
    .peak_volt_mv_o (peak_volt_mv_o),
    .peak_curr_ua_o (peak_curr_ua_o),
    .avg_volt_mv_o  (avg_volt_mv_o),
    .avg_curr_ua_o  (avg_curr_ua_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("Input accepted again while an item was still in progress.");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_valid_o)
    else $error("Result loaded but output valid not raised.");

  a_div_needs_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> (status.run_avg && !in_ready_o))
    else $error("Division started without filled history slots.");

endmodule

// ===== rtl/pmpa_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module pmpa_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pmpa_pkg::DivW-1:0]   dividend_i,
  input  logic [pmpa_pkg::CntW-1:0]   divisor_i,
  output logic [pmpa_pkg::DivW-1:0]   quotient_o,
  output logic                        done_o
);

  logic [pmpa_pkg::DivW-1:0]    quo_q, quo_d;
  logic [pmpa_pkg::CntW-1:0]    rem_q, rem_d;
  logic [pmpa_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [pmpa_pkg::CntW:0]      shifted;
  logic [pmpa_pkg::CntW:0]      diff;
  logic                         ge;

  assign shifted = {rem_q, quo_q[pmpa_pkg::DivW-1]};
  assign ge = shifted >= {1'b0, divisor_i};
  assign diff = shifted - {1'b0, divisor_i};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[pmpa_pkg::CntW-1:0] : shifted[pmpa_pkg::CntW-1:0];
      quo_d = {quo_q[pmpa_pkg::DivW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == pmpa_pkg::DivCntW'(pmpa_pkg::DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign quotient_o = quo_q;
  assign done_o = done_q;

endmodule

// ===== rtl/pmpa_ctrl.sv =====
// Controller state machine that sequences sample update, summing, division and output.
module pmpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  input  pmpa_pkg::status_t status_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output pmpa_pkg::cmd_t    cmd_o
);

  pmpa_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pmpa_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = pmpa_pkg::StEval;
        end
      end
      pmpa_pkg::StEval: begin
        state_d = status_i.run_avg ? pmpa_pkg::StSum : pmpa_pkg::StFinish;
      end
      pmpa_pkg::StSum: begin
        if (status_i.sum_done) begin
          state_d = pmpa_pkg::StDiv;
        end
      end
      pmpa_pkg::StDiv: begin
        if (status_i.div_done) begin
          state_d = pmpa_pkg::StFinish;
        end
      end
      pmpa_pkg::StFinish: begin
        if (slot_free) begin
          state_d = pmpa_pkg::StIdle;
        end
      end
      default: begin
        state_d = pmpa_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      pmpa_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      pmpa_pkg::StEval: begin
        cmd_o.sum_init = status_i.run_avg;
      end
      pmpa_pkg::StSum: begin
        cmd_o.sum_run = 1'b1;
        cmd_o.div_start = status_i.sum_done;
      end
      pmpa_pkg::StDiv: begin
        cmd_o.avg_load = status_i.div_done;
      end
      pmpa_pkg::StFinish: begin
        cmd_o.out_load = slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pmpa_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/pmpa_dp.sv =====
// Datapath with scaling, peaks, history ring, summing and the two dividers.
module pmpa_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pmpa_pkg::cmd_t                   cmd_i,
  output pmpa_pkg::status_t                status_o,
  input  logic                             cfg_valid_i,
  input  logic [pmpa_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [pmpa_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                             operation_i,
  input  logic [pmpa_pkg::BusW-1:0]        raw_bus_i,
  input  logic signed [pmpa_pkg::ShuntW-1:0] raw_shunt_i,
  output logic [pmpa_pkg::VoltW-1:0]       live_volt_mv_o,
  output logic signed [pmpa_pkg::CurrW-1:0] live_curr_ua_o,
  output logic [pmpa_pkg::VoltW-1:0]       peak_volt_mv_o,
  output logic [pmpa_pkg::CurrW-1:0]       peak_curr_ua_o,
  output logic [pmpa_pkg::VoltW-1:0]       avg_volt_mv_o,
  output logic signed [pmpa_pkg::CurrW-1:0] avg_curr_ua_o
);

  localparam int VoltW = pmpa_pkg::VoltW;
  localparam int CurrW = pmpa_pkg::CurrW;
  localparam int CntW = pmpa_pkg::CntW;
  localparam int SlotW = pmpa_pkg::SlotW;
  localparam int VoltSumW = pmpa_pkg::VoltSumW;
  localparam int CurrSumW = pmpa_pkg::CurrSumW;
  localparam int DivW = pmpa_pkg::DivW;

  logic [pmpa_pkg::DecW-1:0] dec_q, dec_d;
  logic [pmpa_pkg::WinW-1:0] win_len_q, win_len_d;

  logic [VoltW-1:0] live_v_q, live_v_d, peak_v_q, peak_v_d, avg_v_q, avg_v_d;
  logic [CurrW-1:0] live_c_q, live_c_d, peak_c_q, peak_c_d, avg_c_q, avg_c_d;
  logic [SlotW-1:0] ws_q, ws_d;
  logic [CntW-1:0]  filled_q, filled_d;
  logic [pmpa_pkg::DecW-1:0] tick_q, tick_d;
  logic             op_q, op_d;
  logic [CntW-1:0]  k_q, k_d;
  logic             rdv_q, rdv_d;

  logic [VoltW-1:0] vmem [pmpa_pkg::WindowSlots];
  logic [CurrW-1:0] cmem [pmpa_pkg::WindowSlots];
  logic [VoltW-1:0] vrd_q;
  logic [CurrW-1:0] crd_q;
  logic [VoltSumW-1:0] acc_v_q;
  logic [CurrSumW-1:0] acc_c_q;

  logic [VoltW-1:0] out_lv_q, out_pv_q, out_av_q;
  logic [CurrW-1:0] out_lc_q, out_pc_q, out_ac_q;

  logic [CntW-1:0]     win;
  logic [VoltW+1:0]    volt_x5;
  logic [VoltW-1:0]    new_volt;
  logic [pmpa_pkg::ShuntW-1:0] shunt_adj;
  logic [CurrW-1:0]    new_curr;
  logic [CurrW-1:0]    new_abs;
  logic [pmpa_pkg::DecW-1:0] tick_inc;
  logic                store;
  logic [SlotW-1:0]    ws_base;
  logic [CntW-1:0]     ws_nxt;
  logic [CntW-1:0]     fill_inc;
  logic [CntW-1:0]     fill_sat;
  logic                mem_we;
  logic                rd_en;
  logic                curr_neg;
  logic [CurrSumW-1:0] curr_mag;
  logic [DivW-1:0]     quo_v, quo_c;
  logic                done_v, done_c;

  always_comb begin
    dec_d = dec_q;
    win_len_d = win_len_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        pmpa_pkg::CfgDecimation: dec_d = cfg_data_i[pmpa_pkg::DecW-1:0];
        pmpa_pkg::CfgWindow:     win_len_d = cfg_data_i[pmpa_pkg::WinW-1:0];
        default: begin
          dec_d = dec_q;
        end
      endcase
    end
  end

  always_comb begin
    if (win_len_q == '0) begin
      win = CntW'(1);
    end else if (int'(win_len_q) > pmpa_pkg::WindowSlots) begin
      win = CntW'(pmpa_pkg::WindowSlots);
    end else begin
      win = CntW'(win_len_q);
    end
  end

  assign volt_x5 = {1'b0, raw_bus_i, 2'b00} + {3'b000, raw_bus_i};
  assign new_volt = volt_x5[VoltW+1:2];
  assign shunt_adj = raw_shunt_i +
                     {{(pmpa_pkg::ShuntW - 2){1'b0}}, {2{raw_shunt_i[pmpa_pkg::ShuntW-1]}}};
  assign new_curr = shunt_adj[pmpa_pkg::ShuntW-1:2];
  assign new_abs = pmpa_pkg::abs_curr(new_curr);

  assign tick_inc = tick_q + 1'b1;
  assign store = tick_inc >= dec_q;
  assign ws_base = (CntW'(ws_q) >= win) ? '0 : ws_q;
  assign ws_nxt = CntW'(ws_base) + 1'b1;
  assign fill_inc = (store && (filled_q < win)) ? filled_q + 1'b1 : filled_q;
  assign fill_sat = (fill_inc > win) ? win : fill_inc;

  assign mem_we = cmd_i.accept && (operation_i == pmpa_pkg::OpSample) && store;
  assign rd_en = cmd_i.sum_run && (k_q < filled_q);

  always_comb begin
    live_v_d = live_v_q;
    live_c_d = live_c_q;
    peak_v_d = peak_v_q;
    peak_c_d = peak_c_q;
    avg_v_d = avg_v_q;
    avg_c_d = avg_c_q;
    ws_d = ws_q;
    filled_d = filled_q;
    tick_d = tick_q;
    op_d = op_q;
    if (cmd_i.accept) begin
      op_d = operation_i;
      if (operation_i == pmpa_pkg::OpClear) begin
        peak_v_d = live_v_q;
        peak_c_d = pmpa_pkg::abs_curr(live_c_q);
        filled_d = '0;
        ws_d = '0;
      end else begin
        live_v_d = new_volt;
        live_c_d = new_curr;
        if (new_volt > peak_v_q) begin
          peak_v_d = new_volt;
        end
        if (new_abs > peak_c_q) begin
          peak_c_d = new_abs;
        end
        tick_d = store ? '0 : tick_inc;
        if (store) begin
          ws_d = (ws_nxt >= win) ? '0 : ws_nxt[SlotW-1:0];
        end
        filled_d = fill_sat;
        if (fill_sat == '0) begin
          avg_v_d = new_volt;
          avg_c_d = new_curr;
        end
      end
    end
    if (cmd_i.avg_load) begin
      avg_v_d = quo_v[VoltW-1:0];
      avg_c_d = curr_neg ? (~quo_c[CurrW-1:0] + 1'b1) : quo_c[CurrW-1:0];
    end
  end

  always_comb begin
    k_d = k_q;
    rdv_d = 1'b0;
    if (cmd_i.sum_init) begin
      k_d = '0;
    end else if (rd_en) begin
      k_d = k_q + 1'b1;
      rdv_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q <= pmpa_pkg::DecReset;
      win_len_q <= pmpa_pkg::WinReset;
      live_v_q <= '0;
      live_c_q <= '0;
      peak_v_q <= '0;
      peak_c_q <= '0;
      avg_v_q <= '0;
      avg_c_q <= '0;
      ws_q <= '0;
      filled_q <= '0;
      tick_q <= '0;
      op_q <= 1'b0;
      k_q <= '0;
      rdv_q <= 1'b0;
    end else begin
      dec_q <= dec_d;
      win_len_q <= win_len_d;
      live_v_q <= live_v_d;
      live_c_q <= live_c_d;
      peak_v_q <= peak_v_d;
      peak_c_q <= peak_c_d;
      avg_v_q <= avg_v_d;
      avg_c_q <= avg_c_d;
      ws_q <= ws_d;
      filled_q <= filled_d;
      tick_q <= tick_d;
      op_q <= op_d;
      k_q <= k_d;
      rdv_q <= rdv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      vmem[ws_base] <= new_volt;
      cmem[ws_base] <= new_curr;
    end
    if (rd_en) begin
      vrd_q <= vmem[k_q[SlotW-1:0]];
      crd_q <= cmem[k_q[SlotW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_init) begin
      acc_v_q <= '0;
      acc_c_q <= '0;
    end else if (rdv_q) begin
      acc_v_q <= acc_v_q + {{(VoltSumW - VoltW){1'b0}}, vrd_q};
      acc_c_q <= acc_c_q + {{(CurrSumW - CurrW){crd_q[CurrW-1]}}, crd_q};
    end
  end

  assign curr_neg = acc_c_q[CurrSumW-1];
  assign curr_mag = curr_neg ? (~acc_c_q + 1'b1) : acc_c_q;

  pmpa_div u_div_volt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_v_q),
    .divisor_i  (filled_q),
    .quotient_o (quo_v),
    .done_o     (done_v)
  );

  pmpa_div u_div_curr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({{(DivW - CurrSumW){1'b0}}, curr_mag}),
    .divisor_i  (filled_q),
    .quotient_o (quo_c),
    .done_o     (done_c)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_lv_q <= live_v_q;
      out_lc_q <= live_c_q;
      out_pv_q <= peak_v_q;
      out_pc_q <= peak_c_q;
      out_av_q <= avg_v_q;
      out_ac_q <= avg_c_q;
    end
  end

  assign status_o.run_avg = (op_q == pmpa_pkg::OpSample) && (filled_q != '0);
  assign status_o.sum_done = (k_q == filled_q) && !rdv_q;
  assign status_o.div_done = done_v && done_c;

  assign live_volt_mv_o = out_lv_q;
  assign live_curr_ua_o = out_lc_q;
  assign peak_volt_mv_o = out_pv_q;
  assign peak_curr_ua_o = out_pc_q;
  assign avg_volt_mv_o = out_av_q;
  assign avg_curr_ua_o = out_ac_q;

endmodule
